@@ hdl/hed_pkg.sv @@
// Shared types, character codes and the entity name table for the HTML
// entity decoder. No dependencies; the files that use it refer to it by scope.
package hed_pkg;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X    = 8'h78;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_NODIGIT = 2'd1;
	localparam logic [1:0] ERR_UNKNOWN = 2'd2;

	localparam int ENTITY_COUNT = 21;
	localparam int ENTITY_LEN_MAX = 5;
	localparam int RESULT_CAP = 8;

	typedef enum logic [1:0] {
		MODE_SCAN         = 2'd0,
		MODE_COLLECT      = 2'd1,
		MODE_DROP_NODIGIT = 2'd2,
		MODE_DROP_UNKNOWN = 2'd3
	} mode_t;

	// Name bytes are left-justified: byte 0 sits in the top eight bits.
	typedef struct packed {
		logic [39:0] text;
		logic [2:0]  len;
		logic [7:0]  code;
	} entity_t;

	// Request from the sequencer to the output stage.
	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic [1:0] err;
		logic       finish;
		logic       string_end;
	} ostage_ctl_t;

	typedef struct packed {
		logic can_emit;
		logic can_finish;
	} ostage_sts_t;

	function automatic entity_t entity_at(input logic [4:0] k);
		entity_t e;
		unique case (k)
			5'd0:    e = '{{"amp", 16'h0},  3'd3, 8'h26};
			5'd1:    e = '{{"lt", 24'h0},   3'd2, 8'h3C};
			5'd2:    e = '{{"gt", 24'h0},   3'd2, 8'h3E};
			5'd3:    e = '{{"nbsp", 8'h0},  3'd4, 8'hA0};
			5'd4:    e = '{{"quot", 8'h0},  3'd4, 8'h22};
			5'd5:    e = '{{"apos", 8'h0},  3'd4, 8'h27};
			5'd6:    e = '{{"sect", 8'h0},  3'd4, 8'hA7};
			5'd7:    e = '{{"euro", 8'h0},  3'd4, 8'h80};
			5'd8:    e = '{"pound",         3'd5, 8'hA3};
			5'd9:    e = '{{"cent", 8'h0},  3'd4, 8'hA2};
			5'd10:   e = '{{"yen", 16'h0},  3'd3, 8'hA5};
			5'd11:   e = '{{"copy", 8'h0},  3'd4, 8'hA9};
			5'd12:   e = '{{"reg", 16'h0},  3'd3, 8'hAE};
			5'd13:   e = '{"trade",         3'd5, 8'h99};
			5'd14:   e = '{{"Auml", 8'h0},  3'd4, 8'hC4};
			5'd15:   e = '{{"auml", 8'h0},  3'd4, 8'hE4};
			5'd16:   e = '{{"Ouml", 8'h0},  3'd4, 8'hD6};
			5'd17:   e = '{{"ouml", 8'h0},  3'd4, 8'hF6};
			5'd18:   e = '{{"Uuml", 8'h0},  3'd4, 8'hDC};
			5'd19:   e = '{{"uuml", 8'h0},  3'd4, 8'hFC};
			5'd20:   e = '{"szlig",         3'd5, 8'hDF};
			default: e = '{40'h0, 3'd0, 8'h00};
		endcase
		return e;
	endfunction

endpackage

@@ hdl/hed_in_if.sv @@
// Input channel of the HTML entity decoder: one string byte per transaction.
// Stands alone; no package needed.
interface hed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_end;

	modport source(output valid, in_byte, string_end, input ready);
	modport sink(input valid, in_byte, string_end, output ready);
endinterface

@@ hdl/hed_out_if.sv @@
// Result channel of the HTML entity decoder: one decoded byte or error per
// transaction. Stands alone; no package needed.
interface hed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] error_code;
	logic       run_last;
	logic       string_done;

	modport source(output valid, out_byte, error_code, run_last, string_done, input ready);
	modport sink(input valid, out_byte, error_code, run_last, string_done, output ready);
endinterface

@@ hdl/hed_num_unit.sv @@
// Shared digit unit: decodes one name byte and folds it into the numeric
// entity value, decimal or hex. Uses nothing from the package.
module hed_num_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       step,
	input  logic       hex,
	input  logic [7:0] ch,
	output logic       is_digit,
	output logic       any_digit,
	output logic [7:0] value
);

	logic [3:0] digit;
	logic [7:0] value_next;
	logic [7:0] value_q;
	logic       any_q;

	always_comb begin
		digit    = 4'd0;
		is_digit = 1'b0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			digit    = 4'(ch - 8'h30);
			is_digit = 1'b1;
		end else if (hex && ch >= 8'h61 && ch <= 8'h66) begin
			digit    = 4'(ch - 8'h57);
			is_digit = 1'b1;
		end else if (hex && ch >= 8'h41 && ch <= 8'h46) begin
			digit    = 4'(ch - 8'h37);
			is_digit = 1'b1;
		end
	end

	// times ten as shift-add for decimal, a nibble shift for hex, kept to the low byte
	assign value_next = hex ? {value_q[3:0], digit}
	                        : 8'((value_q << 3) + (value_q << 1) + {4'd0, digit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (start) begin
			any_q <= 1'b0;
		end else if (step && is_digit) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			value_q <= 8'd0;
		end else if (step && is_digit) begin
			value_q <= value_next;
		end
	end

	assign any_digit = any_q;
	assign value     = value_q;

endmodule

@@ hdl/hed_out_stage.sv @@
// Output stage: holds the newest result back until the next one or the end
// of the item shows whether it is the last. Depends on hed_pkg, hed_out_if.
module hed_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hed_pkg::ostage_ctl_t ctl,
	output hed_pkg::ostage_sts_t sts,
	hed_out_if.source            result
);

	logic       pend_v_q;
	logic [7:0] pend_data_q;
	logic [1:0] pend_err_q;
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_err_q;
	logic       out_last_q;
	logic       out_done_q;
	logic       out_free;
	logic       push;

	assign out_free       = !out_v_q || result.ready;
	assign sts.can_emit   = !pend_v_q || out_free;
	assign sts.can_finish = !pend_v_q || out_free;
	assign push           = pend_v_q && (ctl.emit || ctl.finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.emit) begin
				pend_v_q <= 1'b1;
			end else if (ctl.finish) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			pend_data_q <= ctl.data;
			pend_err_q  <= ctl.err;
		end
		if (push) begin
			out_byte_q <= pend_data_q;
			out_err_q  <= pend_err_q;
			out_last_q <= ctl.finish;
			out_done_q <= ctl.finish && ctl.string_end;
		end
	end

	assign result.valid       = out_v_q;
	assign result.out_byte    = out_byte_q;
	assign result.error_code  = out_err_q;
	assign result.run_last    = out_last_q;
	assign result.string_done = out_done_q;

endmodule

@@ hdl/html_entity_decoder.sv @@
// Top level of the HTML entity decoder. Depends on hed_pkg, hed_in_if,
// hed_out_if, hed_num_unit and hed_out_stage.
//
// One string byte is taken per transaction and the block stays busy until
// every result of that byte has entered the output stage. A plain byte passes
// through take, dispatch, scan, end check and close. The scanner looks at
// each byte in turn; a ';' that closes a name runs the numeric digits through
// the shared digit unit, or walks the name table one entry at a time (up to
// 21 entries tried); an empty or overlong name, or a string end while a name
// is pending, first copies the held name and the unread bytes into the replay
// queue. A result held by a stalled sink stops the sequencer at its next
// result. Up to RESULT_CAP results are produced per byte; any beyond that are
// dropped.
module html_entity_decoder #(
	parameter int NAME_MAX = 6
) (
	input logic       clk,
	input logic       arst_n,
	hed_in_if.sink    item,
	hed_out_if.source result
);

	localparam int QCAP = NAME_MAX + 2;
	localparam int QW   = $clog2(QCAP);
	localparam int LW   = $clog2(QCAP + 1);
	localparam int SW   = $clog2(NAME_MAX);
	localparam int CW   = $clog2(NAME_MAX + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_PROC  = 7'b0000100,
		ST_NUM   = 7'b0001000,
		ST_MATCH = 7'b0010000,
		ST_COPY  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t         state_q;
	hed_pkg::mode_t mode_q;
	logic           end_q;
	logic           bank_q;
	logic [LW-1:0]  qidx_q;
	logic [LW-1:0]  qlen_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  nlen_q;
	logic [CW-1:0]  pos_q;
	logic           hex_q;
	logic [4:0]     ent_q;
	logic [LW-1:0]  cpy_k_q;
	logic [CW-1:0]  cpy_c_q;
	logic [LW-1:0]  cpy_len_q;
	logic [3:0]     ncnt_q;
	logic [7:0]     qbuf_q [2][QCAP];
	logic [7:0]     store_q [NAME_MAX];

	hed_pkg::ostage_ctl_t ctl;
	hed_pkg::ostage_sts_t sts;
	hed_pkg::entity_t     ent;

	logic          accept;
	logic [LW-1:0] src_idx;
	logic [QW-1:0] ridx;
	logic [7:0]    rbyte;
	logic          at_end;
	logic          do_flush;
	logic          col_finish;
	logic          col_store;
	logic          col_replay;
	logic          drop_mode;
	logic          emit_req;
	logic [7:0]    emit_data;
	logic [1:0]    emit_err;
	logic          cap_hit;
	logic          proceed;
	logic          num_start;
	logic          num_more;
	logic          num_digit;
	logic          num_any;
	logic [7:0]    num_value;
	logic [7:0]    num_ch;
	logic          ent_hit;
	logic          ent_last;
	logic          name_hash;
	logic          name_hex;
	logic [LW-1:0] replay_len;

	assign accept     = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);

	assign src_idx = qidx_q + (cpy_k_q - LW'(cpy_c_q));
	assign ridx    = (state_q == ST_COPY) ? src_idx[QW-1:0] : qidx_q[QW-1:0];
	assign rbyte   = qbuf_q[bank_q][ridx];

	assign drop_mode  = (mode_q == hed_pkg::MODE_DROP_NODIGIT) ||
	                    (mode_q == hed_pkg::MODE_DROP_UNKNOWN);
	assign at_end     = (qidx_q == qlen_q);
	assign do_flush   = at_end && end_q && (mode_q == hed_pkg::MODE_COLLECT);
	assign col_finish = (rbyte == hed_pkg::CH_SEMI) && (count_q != '0);
	assign col_store  = (rbyte != hed_pkg::CH_SEMI) && (count_q < CW'(NAME_MAX));
	assign col_replay = !col_finish && !col_store;
	assign replay_len = LW'(count_q) + qlen_q - qidx_q;
	assign name_hash  = (store_q[0] == hed_pkg::CH_HASH);
	assign name_hex   = (count_q >= CW'(2)) && (store_q[1] == hed_pkg::CH_X);

	assign num_ch    = store_q[pos_q[SW-1:0]];
	assign num_more  = (pos_q < nlen_q) && num_digit;
	assign num_start = (state_q == ST_PROC) && !at_end &&
	                   (mode_q == hed_pkg::MODE_COLLECT) && col_finish && name_hash;

	hed_num_unit u_num (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (num_start),
		.step      ((state_q == ST_NUM) && num_more),
		.hex       (hex_q),
		.ch        (num_ch),
		.is_digit  (num_digit),
		.any_digit (num_any),
		.value     (num_value)
	);

	// compare the held name against one table entry per cycle
	always_comb begin
		ent     = hed_pkg::entity_at(ent_q);
		ent_hit = (CW'(ent.len) == nlen_q);
		for (int k = 0; k < hed_pkg::ENTITY_LEN_MAX; k++) begin
			if (CW'(k) < nlen_q && store_q[k] != ent.text[39 - 8 * k -: 8]) begin
				ent_hit = 1'b0;
			end
		end
		ent_last = (ent_q == 5'(hed_pkg::ENTITY_COUNT - 1));
	end

	always_comb begin
		emit_req  = 1'b0;
		emit_data = 8'd0;
		emit_err  = hed_pkg::ERR_NONE;
		unique case (state_q)
			ST_START: begin
				if (drop_mode && end_q) begin
					emit_req = 1'b1;
					emit_err = (mode_q == hed_pkg::MODE_DROP_NODIGIT) ?
					           hed_pkg::ERR_NODIGIT : hed_pkg::ERR_UNKNOWN;
				end
			end
			ST_PROC: begin
				if (do_flush) begin
					emit_req  = 1'b1;
					emit_data = hed_pkg::CH_AMP;
				end else if (!at_end) begin
					if (mode_q == hed_pkg::MODE_SCAN && rbyte != hed_pkg::CH_AMP) begin
						emit_req  = 1'b1;
						emit_data = rbyte;
					end else if (mode_q == hed_pkg::MODE_COLLECT && col_replay) begin
						emit_req  = 1'b1;
						emit_data = hed_pkg::CH_AMP;
					end
				end
			end
			ST_NUM: begin
				if (!num_more) begin
					emit_req = 1'b1;
					if (!num_any) begin
						emit_err = hed_pkg::ERR_NODIGIT;
					end else if (num_value == 8'd0) begin
						emit_err = hed_pkg::ERR_UNKNOWN;
					end else begin
						emit_data = num_value;
					end
				end
			end
			ST_MATCH: begin
				if (ent_hit) begin
					emit_req  = 1'b1;
					emit_data = ent.code;
				end else if (ent_last) begin
					emit_req = 1'b1;
					emit_err = hed_pkg::ERR_UNKNOWN;
				end
			end
			default: ;
		endcase
	end

	assign cap_hit = (ncnt_q == 4'(hed_pkg::RESULT_CAP));
	assign proceed = !emit_req || cap_hit || sts.can_emit;

	assign ctl.emit       = emit_req && !cap_hit && sts.can_emit;
	assign ctl.data       = emit_data;
	assign ctl.err        = emit_err;
	assign ctl.finish     = (state_q == ST_FIN) && sts.can_finish;
	assign ctl.string_end = end_q;

	hed_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= hed_pkg::MODE_SCAN;
			end_q     <= 1'b0;
			bank_q    <= 1'b0;
			qidx_q    <= '0;
			qlen_q    <= '0;
			count_q   <= '0;
			nlen_q    <= '0;
			pos_q     <= '0;
			hex_q     <= 1'b0;
			ent_q     <= 5'd0;
			cpy_k_q   <= '0;
			cpy_c_q   <= '0;
			cpy_len_q <= '0;
			ncnt_q    <= 4'd0;
		end else begin
			if (ctl.emit) begin
				ncnt_q <= ncnt_q + 4'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						end_q   <= item.string_end;
						qidx_q  <= '0;
						qlen_q  <= LW'(1);
						ncnt_q  <= 4'd0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (proceed) begin
						state_q <= drop_mode ? ST_FIN : ST_PROC;
					end
				end
				ST_PROC: begin
					if (at_end) begin
						if (do_flush) begin
							if (proceed) begin
								cpy_k_q   <= '0;
								cpy_c_q   <= count_q;
								cpy_len_q <= replay_len;
								count_q   <= '0;
								mode_q    <= hed_pkg::MODE_SCAN;
								state_q   <= ST_COPY;
							end
						end else begin
							state_q <= ST_FIN;
						end
					end else begin
						unique case (mode_q)
							hed_pkg::MODE_SCAN: begin
								if (rbyte == hed_pkg::CH_AMP) begin
									mode_q  <= hed_pkg::MODE_COLLECT;
									count_q <= '0;
									qidx_q  <= qidx_q + LW'(1);
								end else if (proceed) begin
									qidx_q <= qidx_q + LW'(1);
								end
							end
							hed_pkg::MODE_COLLECT: begin
								if (col_finish) begin
									qidx_q  <= qidx_q + LW'(1);
									mode_q  <= hed_pkg::MODE_SCAN;
									count_q <= '0;
									nlen_q  <= count_q;
									hex_q   <= name_hex;
									pos_q   <= name_hex ? CW'(2) : CW'(1);
									ent_q   <= 5'd0;
									state_q <= name_hash ? ST_NUM : ST_MATCH;
								end else if (col_store) begin
									count_q <= count_q + CW'(1);
									qidx_q  <= qidx_q + LW'(1);
								end else if (proceed) begin
									// replay the held name ahead of the unread bytes
									cpy_k_q   <= '0;
									cpy_c_q   <= count_q;
									cpy_len_q <= replay_len;
									count_q   <= '0;
									mode_q    <= hed_pkg::MODE_SCAN;
									state_q   <= ST_COPY;
								end
							end
							default: begin
								qidx_q <= qidx_q + LW'(1);
							end
						endcase
					end
				end
				ST_NUM: begin
					if (num_more) begin
						pos_q <= pos_q + CW'(1);
					end else if (proceed) begin
						if (!num_any) begin
							mode_q <= hed_pkg::MODE_DROP_NODIGIT;
						end else if (num_value == 8'd0) begin
							mode_q <= hed_pkg::MODE_DROP_UNKNOWN;
						end
						state_q <= ST_PROC;
					end
				end
				ST_MATCH: begin
					if (ent_hit) begin
						if (proceed) begin
							state_q <= ST_PROC;
						end
					end else if (ent_last) begin
						if (proceed) begin
							mode_q  <= hed_pkg::MODE_DROP_UNKNOWN;
							state_q <= ST_PROC;
						end
					end else begin
						ent_q <= ent_q + 5'd1;
					end
				end
				ST_COPY: begin
					if (cpy_k_q == cpy_len_q) begin
						bank_q  <= !bank_q;
						qidx_q  <= '0;
						qlen_q  <= cpy_len_q;
						state_q <= ST_PROC;
					end else begin
						cpy_k_q <= cpy_k_q + LW'(1);
					end
				end
				ST_FIN: begin
					if (sts.can_finish) begin
						if (end_q) begin
							mode_q  <= hed_pkg::MODE_SCAN;
							count_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload storage: replay queue banks and the name bytes
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			qbuf_q[bank_q][0] <= item.in_byte;
		end else if (state_q == ST_COPY && cpy_k_q != cpy_len_q) begin
			qbuf_q[!bank_q][cpy_k_q[QW-1:0]] <=
				(LW'(cpy_c_q) > cpy_k_q) ? store_q[cpy_k_q[SW-1:0]] : rbyte;
		end
		if (state_q == ST_PROC && !at_end && mode_q == hed_pkg::MODE_COLLECT &&
		    col_store) begin
			store_q[count_q[SW-1:0]] <= rbyte;
		end
	end

endmodule

@@ hdl/hed_checker.sv @@
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on hed_pkg and html_entity_decoder.
module hed_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] out_byte,
	input logic [1:0] error_code,
	input logic       run_last,
	input logic       string_done
);

	// hold a result until the sink takes it
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result dropped while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (error_code == hed_pkg::ERR_NONE || error_code == hed_pkg::ERR_NODIGIT ||
		           error_code == hed_pkg::ERR_UNKNOWN))
		else $error("undefined error code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && error_code != hed_pkg::ERR_NONE |-> out_byte == 8'd0)
		else $error("error result carries a nonzero byte");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && string_done |-> run_last)
		else $error("string end not on the last result of its byte");

endmodule

bind html_entity_decoder hed_checker u_hed_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (result.valid),
	.ready       (result.ready),
	.out_byte    (result.out_byte),
	.error_code  (result.error_code),
	.run_last    (result.run_last),
	.string_done (result.string_done)
);

@@ tb/sv/html_entity_decoder_checker.sv @@
// Checker for the HTML entity decoder: watches both channels, predicts the
// decoded bytes of each accepted input transaction and compares results.
// Depends on hed_pkg, hed_in_if and hed_out_if.
`timescale 1ns / 1ps

module html_entity_decoder_checker #(
	parameter int NAME_MAX = 6
) (
	input logic       clk,
	input logic       arst_n,
	hed_in_if.sink    item_mon,
	hed_out_if.sink   result_mon,
	output int        fail_count,
	output int        pending_count
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] error_code;
		logic       run_last;
		logic       string_done;
	} dec_result_t;

	dec_result_t decoded_q[$];
	dec_result_t step_res[$];

	hed_pkg::mode_t mode;
	logic [7:0]     held[NAME_MAX + 1];
	int             held_cnt;

	assign pending_count = decoded_q.size();

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic void put_byte(input logic [7:0] b, input logic [1:0] err);
		dec_result_t r;
		if (step_res.size() < hed_pkg::RESULT_CAP) begin
			r = '{b, err, 1'b0, 1'b0};
			step_res.push_back(r);
		end
	endfunction

	function automatic void flag_error(input logic [1:0] err);
		put_byte(8'h00, err);
		mode = (err == hed_pkg::ERR_NODIGIT) ? hed_pkg::MODE_DROP_NODIGIT :
		                                      hed_pkg::MODE_DROP_UNKNOWN;
	endfunction

	function automatic logic name_is(input string s, input int n);
		if (s.len() != n)
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (held[i] != s[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void close_name();
		int n, pos, digits;
		logic hex;
		logic [7:0] v, c;
		int d;
		string names[hed_pkg::ENTITY_COUNT] = '{"amp", "lt", "gt", "nbsp", "quot",
			"apos", "sect", "euro", "pound", "cent", "yen", "copy", "reg", "trade",
			"Auml", "auml", "Ouml", "ouml", "Uuml", "uuml", "szlig"};
		logic [7:0] codes[hed_pkg::ENTITY_COUNT] = '{8'h26, 8'h3C, 8'h3E, 8'hA0,
			8'h22, 8'h27, 8'hA7, 8'h80, 8'hA3, 8'hA2, 8'hA5, 8'hA9, 8'hAE, 8'h99,
			8'hC4, 8'hE4, 8'hD6, 8'hF6, 8'hDC, 8'hFC, 8'hDF};
		n = held_cnt > NAME_MAX ? NAME_MAX : held_cnt;
		mode = hed_pkg::MODE_SCAN;
		held_cnt = 0;
		if (held[0] == hed_pkg::CH_HASH) begin
			pos = 1;
			digits = 0;
			hex = 1'b0;
			v = 8'h00;
			if (n >= 2 && held[1] == hed_pkg::CH_X) begin
				hex = 1'b1;
				pos = 2;
			end
			for (; pos < n; pos++) begin
				c = held[pos];
				if (c >= "0" && c <= "9")
					d = c - "0";
				else if (hex && c >= "a" && c <= "f")
					d = c - "a" + 10;
				else if (hex && c >= "A" && c <= "F")
					d = c - "A" + 10;
				else
					break;
				v = hex ? 8'((v << 4) | d) : 8'(v * 10 + d);
				digits++;
			end
			if (digits == 0)
				flag_error(hed_pkg::ERR_NODIGIT);
			else if (v == 0)
				flag_error(hed_pkg::ERR_UNKNOWN);
			else
				put_byte(v, hed_pkg::ERR_NONE);
			return;
		end
		for (int k = 0; k < hed_pkg::ENTITY_COUNT; k++)
			if (name_is(names[k], n)) begin
				put_byte(codes[k], hed_pkg::ERR_NONE);
				return;
			end
		flag_error(hed_pkg::ERR_UNKNOWN);
	endfunction

	function automatic void scan_bytes(input logic [7:0] src[$]);
		logic [7:0] q[$];
		logic [7:0] b;
		q = src;
		while (q.size() > 0) begin
			b = q[0];
			if (mode == hed_pkg::MODE_SCAN) begin
				if (b == hed_pkg::CH_AMP) begin
					mode = hed_pkg::MODE_COLLECT;
					held_cnt = 0;
				end else
					put_byte(b, hed_pkg::ERR_NONE);
				void'(q.pop_front());
			end else if (mode == hed_pkg::MODE_COLLECT) begin
				if (b == hed_pkg::CH_SEMI && held_cnt > 0) begin
					close_name();
					void'(q.pop_front());
				end else if (b != hed_pkg::CH_SEMI && held_cnt < NAME_MAX) begin
					held[held_cnt] = b;
					held_cnt++;
					void'(q.pop_front());
				end else begin
					// Emit '&' and rescan the held name ahead of what remains.
					for (int k = held_cnt - 1; k >= 0; k--)
						q.push_front(held[k]);
					while (q.size() > NAME_MAX + 2)
						void'(q.pop_back());
					put_byte(hed_pkg::CH_AMP, hed_pkg::ERR_NONE);
					mode = hed_pkg::MODE_SCAN;
					held_cnt = 0;
				end
			end else
				void'(q.pop_front());
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		logic [7:0] q[$];
		step_res.delete();
		if (mode == hed_pkg::MODE_DROP_NODIGIT || mode == hed_pkg::MODE_DROP_UNKNOWN) begin
			if (last)
				put_byte(8'h00, mode == hed_pkg::MODE_DROP_NODIGIT ?
					hed_pkg::ERR_NODIGIT : hed_pkg::ERR_UNKNOWN);
		end else begin
			q = '{b};
			scan_bytes(q);
			if (last)
				while (mode == hed_pkg::MODE_COLLECT) begin
					q.delete();
					for (int k = 0; k < held_cnt && k < NAME_MAX; k++)
						q.push_back(held[k]);
					put_byte(hed_pkg::CH_AMP, hed_pkg::ERR_NONE);
					mode = hed_pkg::MODE_SCAN;
					held_cnt = 0;
					scan_bytes(q);
				end
		end
		if (last) begin
			mode = hed_pkg::MODE_SCAN;
			held_cnt = 0;
		end
		if (step_res.size() > 0) begin
			step_res[$].run_last = 1'b1;
			step_res[$].string_done = last;
		end
		foreach (step_res[i])
			decoded_q.push_back(step_res[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dec_result_t want;
		if (!arst_n) begin
			mode = hed_pkg::MODE_SCAN;
			held_cnt = 0;
			fail_count = 0;
			decoded_q.delete();
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				if (decoded_q.size() == 0)
					report($sformatf("unexpected result byte %02h err %0d",
						result_mon.out_byte, result_mon.error_code));
				else begin
					want = decoded_q.pop_front();
					if (result_mon.out_byte !== want.out_byte)
						report($sformatf("out_byte %02h, want %02h",
							result_mon.out_byte, want.out_byte));
					if (result_mon.error_code !== want.error_code)
						report($sformatf("error_code %0d, want %0d",
							result_mon.error_code, want.error_code));
					if (result_mon.run_last !== want.run_last)
						report($sformatf("run_last %b, want %b",
							result_mon.run_last, want.run_last));
					if (result_mon.string_done !== want.string_done)
						report($sformatf("string_done %b, want %b",
							result_mon.string_done, want.string_done));
				end
			end
			if (item_mon.valid && item_mon.ready)
				decode_byte(item_mon.in_byte, item_mon.string_end);
		end
	end

endmodule

@@ tb/sv/html_entity_decoder_test.sv @@
// Testbench top for the HTML entity decoder: drives byte strings with
// entities and noise, stalls the result side, and reports the verdict.
// Depends on hed_pkg, hed_in_if, hed_out_if and html_entity_decoder_checker.
`timescale 1ns / 1ps

module html_entity_decoder_test;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	logic calm;

	hed_in_if  item();
	hed_out_if result();

	html_entity_decoder dut (.clk(clk), .arst_n(arst_n), .item(item), .result(result));

	html_entity_decoder_checker checker_i (
		.clk(clk), .arst_n(arst_n), .item_mon(item), .result_mon(result),
		.fail_count(fail_count), .pending_count(pending_count));

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Sink stalls at random with a chance of one in ten, never during the calm stretch.
	always @(negedge clk) begin
		result.ready <= calm || ($urandom_range(99) >= 10);
	end

	// Leave valid high after a transaction; the next call replaces or drops it, or the stimulus end drops it.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(99) < 10) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid      <= 1'b1;
		item.in_byte    <= b;
		item.string_end <= last;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic end_it);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], end_it && i == s.len() - 1);
	endtask

	function automatic string pick_body();
		string names[hed_pkg::ENTITY_COUNT] = '{"amp", "lt", "gt", "nbsp", "quot",
			"apos", "sect", "euro", "pound", "cent", "yen", "copy", "reg", "trade",
			"Auml", "auml", "Ouml", "ouml", "Uuml", "uuml", "szlig"};
		string hx = "0123456789abcdefABCDEF";
		string s;
		case ($urandom_range(5))
			0, 1: s = names[$urandom_range(hed_pkg::ENTITY_COUNT - 1)];
			2: s = $sformatf("#%0d", $urandom_range(300));
			3: begin
				s = "#x";
				repeat ($urandom_range(1, 4))
					s = {s, string'(hx[$urandom_range(21)])};
			end
			4: s = {"#", ($urandom_range(1) ? "x" : ""), "q"};
			default: begin
				s = "";
				repeat ($urandom_range(0, 8))
					s = {s, string'(byte'($urandom_range(255)))};
			end
		endcase
		return s;
	endfunction

	initial begin
		int sent;
		string s;
		arst_n = 1'b0;
		calm = 1'b0;
		item.valid = 1'b0;
		item.in_byte = 8'h00;
		item.string_end = 1'b0;
		result.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, every entity form, errors, empty and overlong names.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_text("a&amp;&lt;&szlig;&Auml;b", 1'b1);
		send_text("&;x&#65;&#x4a;&#xFF;z", 1'b1);
		send_text("&#;ab", 1'b1);
		send_text("&#x;q", 1'b1);
		send_text("&#0;q", 1'b1);
		send_text("&bogus;qq", 1'b1);
		send_text("&abcdefg&lt;", 1'b1);
		send_text("&a&b&", 1'b1);
		send_text("&#12ab;&#X41;", 1'b1);
		sent = 101;

		while (sent < 260) begin
			calm = (sent > 180 && sent < 230);
			s = "";
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(3) == 0)
					s = {s, string'(byte'($urandom_range(255)))};
				s = {s, "&", pick_body(), ($urandom_range(5) == 0 ? "" : ";")};
			end
			if ($urandom_range(4) == 0)
				s = {s, string'(byte'($urandom_range(255)))};
			send_text(s, 1'b1);
			sent += s.len();
		end
		calm = 1'b0;
		item.valid <= 1'b0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
